[rtl/core/bbs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bouncing ball step block.
// No dependencies; imported by every module of the block.
package bbs_pkg;

   localparam int DATA_W    = 32;   // external word fields
   localparam int RADIUS_W  = 31;
   localparam int FACTOR_W  = 17;   // unsigned Q1.16 factors, 1.0 included
   localparam int TSTEP_W   = 16;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int PC_W      = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_RESET  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LAUNCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GROUND   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTIT   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FRICTION = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [DATA_W-1:0]  force_x;
      logic signed [DATA_W-1:0]  force_y;
      logic [TSTEP_W-1:0]        timestep;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic                     on_ground;
   } rsp_payload_type;

   // multiplier operand and factor selects
   typedef enum logic [2:0] {
      SRC_VX, SRC_VY, SRC_NVX, SRC_NVY, SRC_GY
   } mul_src_type;

   typedef enum logic [1:0] {
      FAC_DT, FAC_REST, FAC_FRIC
   } mul_fac_type;

   // state write-back operations
   typedef enum logic [3:0] {
      WB_NONE, WB_RESET, WB_LAUNCH, WB_PX_ADD, WB_PY_ADD, WB_PY_CLAMP,
      WB_PX_CLAMP, WB_VX_PROD, WB_VY_PROD, WB_VY_ADD
   } wb_op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS, COND_HIT_Y, COND_HIT_X, COND_REST
   } cond_type;

   typedef struct packed {
      logic        mul_en;
      mul_src_type mul_a;
      mul_fac_type mul_f;
      wb_op_type   wb;
   } exec_type;

   typedef struct packed {
      cond_type         cond;
      logic [PC_W-1:0]  target;
      logic             last;
      exec_type         op;
   } ctl_word_type;

endpackage

[rtl/core/bbs_mul.sv]
`timescale 1ns / 1ps
// Shared fixed-point multiplier: signed operand times Q1.16 factor,
// truncated toward zero, registered. Depends on bbs_pkg.
module bbs_mul
   import bbs_pkg::*;
#(
   parameter int OP_W      = 33,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [OP_W-1:0]            op_a,
   input  logic [FACTOR_W-1:0]               factor,
   output logic signed [OP_W+FACTOR_W:0]     prod
);

   localparam int MW = OP_W + FACTOR_W;
   localparam int PW = MW + 1;

   logic                  neg;
   logic [OP_W-1:0]       mag;
   logic [MW-1:0]         mag_prod;
   logic [MW-1:0]         scaled;
   logic signed [PW-1:0]  pos_val;
   logic signed [PW-1:0]  prod_ff;
   logic signed [PW-1:0]  prod_in;

   // multiply the magnitude so the shift truncates toward zero
   always_comb begin
      neg      = op_a[OP_W-1];
      mag      = neg ? unsigned'(-op_a) : unsigned'(op_a);
      mag_prod = MW'(mag) * MW'(factor);
      scaled   = mag_prod >> FRAC_BITS;
      pos_val  = $signed({1'b0, scaled});
      prod_in  = neg ? -pos_val : pos_val;
   end

   // hold the product until the next multiply
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[rtl/core/bbs_datapath.sv]
`timescale 1ns / 1ps
// Ball state, configuration registers, wide adders, clamps and hit tests.
// Driven by the control word from bbs_sequencer; depends on bbs_pkg.
module bbs_datapath
   import bbs_pkg::*;
#(
   parameter int WORD_WIDTH = 32,
   parameter int OP_W       = 33
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_accept,
   input  req_payload_type                   req_payload,
   input  logic                              csr_write,
   input  logic [CSR_IDX_W-1:0]              csr_index,
   input  logic [DATA_W-1:0]                 csr_data,
   input  exec_type                          exec,
   input  logic signed [OP_W+FACTOR_W:0]     prod,
   output logic signed [OP_W-1:0]            mul_a,
   output logic [FACTOR_W-1:0]               mul_f,
   output logic                              hit_y,
   output logic                              hit_x,
   output logic                              resting,
   output rsp_payload_type                   view
);

   localparam int PW = OP_W + FACTOR_W + 1;
   localparam int XW = PW + 2;
   localparam logic signed [XW-1:0] SAT_HI =
      {{(XW-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
   localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

   logic signed [WORD_WIDTH-1:0] px_ff, py_ff, vx_ff, vy_ff;
   logic signed [WORD_WIDTH-1:0] px_in, py_in, vx_in, vy_in;

   logic [RADIUS_W-1:0]      radius_ff;
   logic signed [DATA_W-1:0] left_ff, right_ff, ground_ff, ceil_ff, grav_ff;
   logic [FACTOR_W-1:0]      rest_ff, fric_ff;

   logic signed [DATA_W-1:0] fx_ff, fy_ff;
   logic [TSTEP_W-1:0]       dt_ff;

   logic signed [XW-1:0] w_r, w_lw, w_rw, w_gl, w_cl;
   logic signed [XW-1:0] w_px, w_py, w_vx, w_vy, w_prod;
   logic signed [XW-1:0] w_fx, w_fy, fx_adj, fy_adj, w_hx, w_hy;
   logic                 ground_hit, ceil_hit, left_hit, right_hit;

   function automatic logic signed [WORD_WIDTH-1:0] sat_w(input logic signed [XW-1:0] v);
      logic signed [WORD_WIDTH-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[WORD_WIDTH-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[WORD_WIDTH-1:0];
      end else begin
         r = v[WORD_WIDTH-1:0];
      end
      return r;
   endfunction

   // widen every operand so sums and compares are exact
   always_comb begin
      w_r    = XW'(radius_ff);
      w_lw   = XW'(left_ff);
      w_rw   = XW'(right_ff);
      w_gl   = XW'(ground_ff);
      w_cl   = XW'(ceil_ff);
      w_px   = XW'(px_ff);
      w_py   = XW'(py_ff);
      w_vx   = XW'(vx_ff);
      w_vy   = XW'(vy_ff);
      w_prod = XW'(prod);
      w_fx   = XW'(fx_ff);
      w_fy   = XW'(fy_ff);
   end

   // halve the launch force, rounding toward zero
   always_comb begin
      fx_adj = w_fx + $signed({{(XW-1){1'b0}}, w_fx[XW-1]});
      fy_adj = w_fy + $signed({{(XW-1){1'b0}}, w_fy[XW-1]});
      w_hx   = fx_adj >>> 1;
      w_hy   = fy_adj >>> 1;
   end

   // wall and floor tests; ground wins over ceiling, left over right
   always_comb begin
      ground_hit = (w_py - w_r < w_gl) && vy_ff[WORD_WIDTH-1];
      ceil_hit   = (w_py + w_r > w_cl) && !vy_ff[WORD_WIDTH-1] && (|vy_ff);
      left_hit   = (w_px - w_r < w_lw) && vx_ff[WORD_WIDTH-1];
      right_hit  = (w_px + w_r > w_rw) && !vx_ff[WORD_WIDTH-1] && (|vx_ff);
      hit_y      = ground_hit || ceil_hit;
      hit_x      = left_hit || right_hit;
      resting    = (w_py == w_r + w_gl);
   end

   // select the multiplier operands
   always_comb begin
      unique case (exec.mul_a)
         SRC_VX:  mul_a = OP_W'(vx_ff);
         SRC_VY:  mul_a = OP_W'(vy_ff);
         SRC_NVX: mul_a = -OP_W'(vx_ff);
         SRC_NVY: mul_a = -OP_W'(vy_ff);
         SRC_GY:  mul_a = OP_W'(grav_ff);
         default: mul_a = '0;
      endcase
      unique case (exec.mul_f)
         FAC_DT:   mul_f = FACTOR_W'(dt_ff);
         FAC_REST: mul_f = rest_ff;
         FAC_FRIC: mul_f = fric_ff;
         default:  mul_f = '0;
      endcase
   end

   // state write-back
   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      unique case (exec.wb)
         WB_NONE: begin
         end
         WB_RESET: begin
            px_in = sat_w(w_r + w_lw);
            py_in = sat_w(w_r);
            vx_in = '0;
            vy_in = '0;
         end
         WB_LAUNCH: begin
            vx_in = sat_w(w_vx + w_hx);
            vy_in = sat_w(w_vy + w_hy);
         end
         WB_PX_ADD:   px_in = sat_w(w_px + w_prod);
         WB_PY_ADD:   py_in = sat_w(w_py + w_prod);
         WB_PY_CLAMP: py_in = ground_hit ? sat_w(w_r + w_gl) : sat_w(w_cl - w_r);
         WB_PX_CLAMP: px_in = left_hit ? sat_w(w_lw + w_r) : sat_w(w_rw - w_r);
         WB_VX_PROD:  vx_in = sat_w(w_prod);
         WB_VY_PROD:  vy_in = sat_w(w_prod);
         WB_VY_ADD:   vy_in = sat_w(w_vy + w_prod);
         default: begin
         end
      endcase
   end

   // ball state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff     <= '0;
         py_ff     <= '0;
         vx_ff     <= '0;
         vy_ff     <= '0;
         radius_ff <= RADIUS_W'(65536);
         left_ff   <= '0;
         right_ff  <= DATA_W'(65536000);
         ground_ff <= '0;
         ceil_ff   <= DATA_W'(65536000);
         grav_ff   <= -DATA_W'(642253);
         rest_ff   <= FACTOR_W'(45875);
         fric_ff   <= FACTOR_W'(32768);
      end else begin
         px_ff <= px_in;
         py_ff <= py_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_RADIUS:   radius_ff <= csr_data[RADIUS_W-1:0];
               CSR_LEFT:     left_ff   <= csr_data;
               CSR_RIGHT:    right_ff  <= csr_data;
               CSR_GROUND:   ground_ff <= csr_data;
               CSR_CEILING:  ceil_ff   <= csr_data;
               CSR_GRAVITY:  grav_ff   <= csr_data;
               CSR_RESTIT:   rest_ff   <= csr_data[FACTOR_W-1:0];
               CSR_FRICTION: fric_ff   <= csr_data[FACTOR_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // latch the operands of an accepted item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         fx_ff <= req_payload.force_x;
         fy_ff <= req_payload.force_y;
         dt_ff <= req_payload.timestep;
      end
   end

   // current state as a result item
   always_comb begin
      view.pos_x     = DATA_W'(px_ff);
      view.pos_y     = DATA_W'(py_ff);
      view.vel_x     = DATA_W'(vx_ff);
      view.vel_y     = DATA_W'(vy_ff);
      view.on_ground = resting;
   end

endmodule

[rtl/core/bbs_sequencer.sv]
`timescale 1ns / 1ps
// Microcode sequencer for the datapath, depends on bbs_pkg: program ROM,
// step counter, conditional jumps; one control word a cycle unless held.
module bbs_sequencer
   import bbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic              hit_y,
   input  logic              hit_x,
   input  logic              resting,
   input  logic              rsp_free,
   output exec_type          exec,
   output logic              publish
);

   // program entry points and jump targets
   localparam logic [PC_W-1:0] PC_RESET    = 5'd0;
   localparam logic [PC_W-1:0] PC_LAUNCH   = 5'd2;
   localparam logic [PC_W-1:0] PC_NOP_CMD  = 5'd4;
   localparam logic [PC_W-1:0] PC_STEP     = 5'd5;
   localparam logic [PC_W-1:0] PC_BOUNCE_X = 5'd10;
   localparam logic [PC_W-1:0] PC_FRICTION = 5'd12;
   localparam logic [PC_W-1:0] PC_GRAVITY  = 5'd14;

   localparam exec_type IDLE_OP = '{mul_en: 1'b0, mul_a: SRC_VX, mul_f: FAC_DT,
                                    wb: WB_NONE};

   typedef enum logic {
      S_IDLE, S_RUN
   } state_type;

   state_type       state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   ctl_word_type    word;
   logic            cond_true;

   function automatic ctl_word_type rom_word(input logic [PC_W-1:0] addr);
      ctl_word_type w;
      w = '{cond: COND_ALWAYS, target: '0, last: 1'b0, op: IDLE_OP};
      unique case (addr)
         5'd0:  w.op.wb = WB_RESET;
         5'd1:  w.last  = 1'b1;
         5'd2:  w.op.wb = WB_LAUNCH;
         5'd3:  w.last  = 1'b1;
         5'd4:  w.last  = 1'b1;
         5'd5:  w.op = '{mul_en: 1'b1, mul_a: SRC_VX, mul_f: FAC_DT, wb: WB_NONE};
         5'd6:  w.op = '{mul_en: 1'b1, mul_a: SRC_VY, mul_f: FAC_DT, wb: WB_PX_ADD};
         5'd7:  w.op.wb = WB_PY_ADD;
         5'd8: begin
            w.cond   = COND_HIT_Y;
            w.target = PC_BOUNCE_X;
            w.op = '{mul_en: 1'b1, mul_a: SRC_NVY, mul_f: FAC_REST, wb: WB_PY_CLAMP};
         end
         5'd9:  w.op.wb = WB_VY_PROD;
         5'd10: begin
            w.cond   = COND_HIT_X;
            w.target = PC_FRICTION;
            w.op = '{mul_en: 1'b1, mul_a: SRC_NVX, mul_f: FAC_REST, wb: WB_PX_CLAMP};
         end
         5'd11: w.op.wb = WB_VX_PROD;
         5'd12: begin
            w.cond   = COND_REST;
            w.target = PC_GRAVITY;
            w.op = '{mul_en: 1'b1, mul_a: SRC_VX, mul_f: FAC_FRIC, wb: WB_NONE};
         end
         5'd13: w.op.wb = WB_VX_PROD;
         5'd14: w.op = '{mul_en: 1'b1, mul_a: SRC_GY, mul_f: FAC_DT, wb: WB_NONE};
         5'd15: w.op.wb = WB_VY_ADD;
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

   function automatic logic [PC_W-1:0] entry_pc(input logic [CMD_W-1:0] cmd);
      logic [PC_W-1:0] p;
      unique case (cmd)
         CMD_RESET:  p = PC_RESET;
         CMD_LAUNCH: p = PC_LAUNCH;
         CMD_STEP:   p = PC_STEP;
         default:    p = PC_NOP_CMD;
      endcase
      return p;
   endfunction

   assign word = rom_word(pc_ff);

   // evaluate the jump condition of the current word
   always_comb begin
      unique case (word.cond)
         COND_ALWAYS: cond_true = 1'b1;
         COND_HIT_Y:  cond_true = hit_y;
         COND_HIT_X:  cond_true = hit_x;
         COND_REST:   cond_true = resting;
         default:     cond_true = 1'b1;
      endcase
   end

   // advance the program; hold on the final word until the output is free
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      exec      = IDLE_OP;
      publish   = 1'b0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pc_in    = entry_pc(req_command);
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (word.last) begin
               if (rsp_free) begin
                  publish  = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (cond_true) begin
               exec  = word.op;
               pc_in = pc_ff + PC_W'(1);
            end else begin
               pc_in = word.target;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= PC_RESET;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

endmodule

[rtl/core/bouncing_ball_step.sv]
`timescale 1ns / 1ps
// Bouncing ball step: one item is in work at a time. Reset, launch and an
// unused command run straight-line microcode; a time step runs the hit tests,
// and their jumps decide its length. The sequencer returns to idle as the
// result is loaded, so the next item can be taken while the result is offered.
// Step time is set by the microprogram length and the single shared multiplier.
// Synchronous reset clears the ball state, loads register defaults, drops work.
module bouncing_ball_step
   import bbs_pkg::*;
#(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]      csr_data
);

   localparam int OP_W = (WORD_WIDTH + 1 > DATA_W) ? WORD_WIDTH + 1 : DATA_W;
   localparam int PW   = OP_W + FACTOR_W + 1;

   exec_type              exec;
   logic                  publish;
   logic                  rsp_free;
   logic                  hit_y, hit_x, resting;
   logic signed [OP_W-1:0] mul_a;
   logic [FACTOR_W-1:0]   mul_f;
   logic signed [PW-1:0]  prod;
   rsp_payload_type       view;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff;

   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   bbs_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_payload.command),
      .hit_y       (hit_y),
      .hit_x       (hit_x),
      .resting     (resting),
      .rsp_free    (rsp_free),
      .exec        (exec),
      .publish     (publish)
   );

   bbs_datapath #(
      .WORD_WIDTH (WORD_WIDTH),
      .OP_W       (OP_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_valid && req_ready),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .exec        (exec),
      .prod        (prod),
      .mul_a       (mul_a),
      .mul_f       (mul_f),
      .hit_y       (hit_y),
      .hit_x       (hit_x),
      .resting     (resting),
      .view        (view)
   );

   bbs_mul #(
      .OP_W      (OP_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .enable (exec.mul_en),
      .op_a   (mul_a),
      .factor (mul_f),
      .prod   (prod)
   );

   // output register: load on publish, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (publish) begin
         rsp_payload_ff <= view;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[rtl/core/bbs_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for bouncing_ball_step, attached by bind.
// Depends on bbs_pkg and the top-level port list.
module bbs_checker
   import bbs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_payload_type       rsp_payload,
   input logic                  csr_valid,
   input logic                  csr_ready
);

   // result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result changed while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item accepted while one is in work");

   // a new result only comes from an item in work, and frees the input
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready) && req_ready)
      else $error("result appeared without an item in work");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind bouncing_ball_step bbs_checker u_bbs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready)
);
